@@ src/g2e_pkg.sv @@
// g2e_pkg: types, constants and the arctangent table for the geodetic to ECEF converter.
// Used by every module under src; depends on nothing.
package g2e_pkg;

   localparam int ITERATIONS_DEF = 32;
   localparam int TAB_LEN        = 48;
   localparam int SQRT_STEPS     = 32;
   localparam int DIV_STEPS      = 36;

   localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE    = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN  = 34'sd2147483648;
   localparam logic signed [33:0] OUT_LIMIT  = 34'sd6500000000;
   localparam logic [33:0]        AXIS_RESET = 34'd6378137000;
   localparam logic [36:0]        FLAT_RESET = 37'd3686454314;

   localparam logic [7:0] CSR_AXIS = 8'd0;
   localparam logic [7:0] CSR_FLAT = 8'd1;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               flip;
   } cordic_type;

   typedef struct packed {
      logic [63:0] d;
      logic [63:0] res;
   } sqrt_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [35:0] bits;
      logic [30:0] r;
   } div_type;

   typedef struct packed {
      logic signed [31:0] clat;
      logic signed [31:0] slat;
      logic signed [31:0] clon;
      logic signed [31:0] slon;
      logic signed [27:0] h;
   } side_type;

   // arctangent of 2^-i in binary-angle units
   function automatic logic signed [33:0] atan_entry(input int idx);
      logic signed [33:0] v;
      unique case (idx)
         0:  v = 34'sd536870912;
         1:  v = 34'sd316933406;
         2:  v = 34'sd167458907;
         3:  v = 34'sd85004756;
         4:  v = 34'sd42667331;
         5:  v = 34'sd21354465;
         6:  v = 34'sd10679838;
         7:  v = 34'sd5340245;
         8:  v = 34'sd2670163;
         9:  v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         24: v = 34'sd41;
         25: v = 34'sd20;
         26: v = 34'sd10;
         27: v = 34'sd5;
         28: v = 34'sd3;
         29: v = 34'sd1;
         30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

@@ src/g2e_cordic_cell.sv @@
// g2e_cordic_cell: one rotation step of the sine/cosine CORDIC, registered.
// Depends on g2e_pkg.
module g2e_cordic_cell import g2e_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       en,
   input  cordic_type cur,
   output cordic_type nxt
);

   localparam logic signed [33:0] ANGLE = atan_entry(STAGE);

   logic signed [33:0] x_w, y_w, dx, dy;
   cordic_type nxt_in, nxt_ff;

   assign x_w = cur.x;
   assign y_w = cur.y;
   assign dx  = y_w >>> STAGE;
   assign dy  = x_w >>> STAGE;

   always_comb begin
      nxt_in.flip = cur.flip;
      if (!cur.z[33]) begin
         nxt_in.x = x_w - dx;
         nxt_in.y = y_w + dy;
         nxt_in.z = cur.z - ANGLE;
      end else begin
         nxt_in.x = x_w + dx;
         nxt_in.y = y_w - dy;
         nxt_in.z = cur.z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) nxt_ff <= nxt_in;
   end

   assign nxt = nxt_ff;

endmodule

@@ src/g2e_sqrt_cell.sv @@
// g2e_sqrt_cell: one digit step of the bit-serial integer square root, registered.
// Depends on g2e_pkg.
module g2e_sqrt_cell import g2e_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type cur,
   output sqrt_type nxt
);

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic [63:0] trial;
   sqrt_type nxt_in, nxt_ff;

   assign trial = cur.res + BIT;

   always_comb begin
      if (cur.d >= trial) begin
         nxt_in.d   = cur.d - trial;
         nxt_in.res = (cur.res >> 1) + BIT;
      end else begin
         nxt_in.d   = cur.d;
         nxt_in.res = cur.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) nxt_ff <= nxt_in;
   end

   assign nxt = nxt_ff;

endmodule

@@ src/g2e_div_cell.sv @@
// g2e_div_cell: one quotient bit of the restoring divider, registered.
// Depends on g2e_pkg.
module g2e_div_cell import g2e_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  div_type cur,
   output div_type nxt
);

   logic [31:0] rem2;
   logic        ge;
   div_type     nxt_in, nxt_ff;

   // dividend bits leave at the top of bits, quotient bits enter at the bottom
   assign rem2 = {cur.rem[30:0], cur.bits[35]};
   assign ge   = rem2 >= {1'b0, cur.r};

   always_comb begin
      nxt_in.r    = cur.r;
      nxt_in.rem  = ge ? rem2 - {1'b0, cur.r} : rem2;
      nxt_in.bits = {cur.bits[34:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) nxt_ff <= nxt_in;
   end

   assign nxt = nxt_ff;

endmodule

@@ src/g2e_mulq30.sv @@
// g2e_mulq30: length times Q2.30 factor, rounded half up, two register stages.
// Depends on g2e_pkg.
module g2e_mulq30 import g2e_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [37:0] v,
   input  logic signed [31:0] c,
   output logic signed [37:0] p
);

   logic signed [16:0] ch;
   logic signed [15:0] cl;
   logic signed [54:0] hi_ff;
   logic signed [53:0] lo_ff;
   logic signed [70:0] sum;
   logic signed [37:0] p_ff;

   assign ch = c[31:15];
   assign cl = {1'b0, c[14:0]};

   assign sum = (71'(hi_ff) <<< 15) + 71'(lo_ff) + (71'sd1 <<< 29);

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff <= v * ch;
         lo_ff <= v * cl;
         p_ff  <= sum[67:30];
      end
   end

   assign p = p_ff;

endmodule

@@ src/geodetic_to_ecef_top.sv @@
// geodetic_to_ecef_top: fixed-point geodetic to ECEF pipeline, CSR block and flow control.
// Depends on g2e_pkg and the cordic, sqrt, divider and multiplier cells.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | latitude, longitude, height_mm
//  rsp     | out       | rsp_valid/rsp_stall | x_mm, y_mm, z_mm
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One word accepted per cycle unless a result is stalled; the data passes the CORDIC row,
// 32 square-root cells, 36 divider cells and two two-stage multiplier rows.
// Synchronous reset clears the valid line and loads the CSRs with their reset values.
// A stalled result freezes the whole row; req_stall rises in that cycle.
// CSR writes always complete; derived terms settle through omf_ff, omf2_ff and ee_ff.
module geodetic_to_ecef_top import g2e_pkg::*; #(
   parameter int ITERATIONS = ITERATIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_latitude,
   input  logic signed [31:0] req_longitude,
   input  logic signed [27:0] req_height_mm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [33:0] rsp_x_mm,
   output logic signed [33:0] rsp_y_mm,
   output logic signed [33:0] rsp_z_mm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [36:0]        csr_data
);

   localparam int LAT = ITERATIONS + 76;

   function automatic cordic_type prep_angle(input logic signed [31:0] a);
      cordic_type c;
      logic signed [33:0] w;
      w = 34'(a);
      c.x = CORDIC_K;
      c.y = 34'sd0;
      c.flip = 1'b0;
      c.z = w;
      if (w > Q30_ONE) begin
         c.z = w - HALF_TURN;
         c.flip = 1'b1;
      end else if (w < -Q30_ONE) begin
         c.z = w + HALF_TURN;
         c.flip = 1'b1;
      end
      return c;
   endfunction

   function automatic logic signed [33:0] sat(input logic signed [37:0] v);
      logic signed [33:0] r;
      if (v > 38'(OUT_LIMIT)) r = OUT_LIMIT;
      else if (v < -38'(OUT_LIMIT)) r = -OUT_LIMIT;
      else r = v[33:0];
      return r;
   endfunction

   // ---- CSRs and derived ellipsoid terms
   logic [33:0] axis_ff;
   logic [36:0] flat_ff;
   logic [40:0] omf_w;
   logic [61:0] omf_sq;
   logic [30:0] omf_ff, omf2_ff, ee_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= AXIS_RESET;
         flat_ff <= FLAT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_AXIS: axis_ff <= csr_data[33:0];
            CSR_FLAT: flat_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign omf_w  = (41'd1 << 40) - {4'b0, flat_ff} + 41'd512;
   assign omf_sq = omf_ff * omf_ff + (62'd1 << 29);

   always_ff @(posedge clock) begin
      omf_ff  <= omf_w[40:10];
      omf2_ff <= omf_sq[60:30];
      ee_ff   <= 31'h40000000 - omf2_ff;
   end

   // ---- flow control
   logic            advance, accept;
   logic [LAT-1:0]  valid_ff;
   logic            rsp_valid_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && advance;
   assign req_stall = reset || !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[LAT-2:0], accept};
         rsp_valid_ff <= valid_ff[LAT-1];
      end
   end

   // ---- CORDIC row, latitude and longitude side by side
   cordic_type         lat_c [0:ITERATIONS];
   cordic_type         lon_c [0:ITERATIONS];
   logic signed [27:0] h_ff  [0:ITERATIONS];
   cordic_type         prep_lat_ff, prep_lon_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_lat_ff <= prep_angle(req_latitude);
         prep_lon_ff <= prep_angle(req_longitude);
         h_ff[0]     <= req_height_mm;
      end
   end

   assign lat_c[0] = prep_lat_ff;
   assign lon_c[0] = prep_lon_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_cordic
      g2e_cordic_cell #(.STAGE(i)) u_lat (
         .clock(clock), .en(advance), .cur(lat_c[i]), .nxt(lat_c[i+1]));
      g2e_cordic_cell #(.STAGE(i)) u_lon (
         .clock(clock), .en(advance), .cur(lon_c[i]), .nxt(lon_c[i+1]));
      always_ff @(posedge clock) begin
         if (advance) h_ff[i+1] <= h_ff[i];
      end
   end

   // ---- final signs and sin^2 lat
   logic signed [33:0] clat_w, slat_w, clon_w, slon_w;
   logic signed [31:0] slat32;
   logic signed [63:0] s2_prod;
   logic [30:0]        s2_in, s2_ff;
   side_type           side_in, side_a_ff;

   assign clat_w = lat_c[ITERATIONS].flip ? -lat_c[ITERATIONS].x : lat_c[ITERATIONS].x;
   assign slat_w = lat_c[ITERATIONS].flip ? -lat_c[ITERATIONS].y : lat_c[ITERATIONS].y;
   assign clon_w = lon_c[ITERATIONS].flip ? -lon_c[ITERATIONS].x : lon_c[ITERATIONS].x;
   assign slon_w = lon_c[ITERATIONS].flip ? -lon_c[ITERATIONS].y : lon_c[ITERATIONS].y;
   assign slat32 = slat_w[31:0];
   assign s2_prod = slat32 * slat32;

   always_comb begin
      side_in.clat = clat_w[31:0];
      side_in.slat = slat_w[31:0];
      side_in.clon = clon_w[31:0];
      side_in.slon = slon_w[31:0];
      side_in.h    = h_ff[ITERATIONS];
      if (s2_prod[63:30] > 34'h40000000) s2_in = 31'h40000000;
      else s2_in = s2_prod[60:30];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_a_ff <= side_in;
         s2_ff     <= s2_in;
      end
   end

   // ---- denominator 1 - e^2 sin^2, then square root row
   logic [61:0]        es;
   logic signed [32:0] den;
   sqrt_type           sq_b_in, sq_b_ff;
   sqrt_type           sq     [0:SQRT_STEPS];
   side_type           side_s [0:SQRT_STEPS];

   assign es = ee_ff * s2_ff;

   always_comb begin
      den = 33'sh40000000 - $signed({1'b0, es[61:30]});
      if (den < 33'sd1) den = 33'sd1;
      sq_b_in.d   = {1'b0, den, 30'b0};
      sq_b_in.res = 64'd0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_b_ff   <= sq_b_in;
         side_s[0] <= side_a_ff;
      end
   end

   assign sq[0] = sq_b_ff;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      g2e_sqrt_cell #(.STEP(j)) u_cell (
         .clock(clock), .en(advance), .cur(sq[j]), .nxt(sq[j+1]));
      always_ff @(posedge clock) begin
         if (advance) side_s[j+1] <= side_s[j];
      end
   end

   // ---- N = a * 2^30 / r, restoring divider row
   div_type  dv_d_in, dv_d_ff;
   div_type  dv      [0:DIV_STEPS];
   side_type side_dv [0:DIV_STEPS];

   // quotient stays below 2^35, so the top dividend bits start as remainder
   always_comb begin
      dv_d_in.rem  = {4'b0, axis_ff[33:6]};
      dv_d_in.bits = {axis_ff[5:0], 30'b0};
      dv_d_in.r    = sq[SQRT_STEPS].res[30:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_d_ff    <= dv_d_in;
         side_dv[0] <= side_s[SQRT_STEPS];
      end
   end

   assign dv[0] = dv_d_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      g2e_div_cell u_cell (
         .clock(clock), .en(advance), .cur(dv[k]), .nxt(dv[k+1]));
      always_ff @(posedge clock) begin
         if (advance) side_dv[k+1] <= side_dv[k];
      end
   end

   // ---- products
   logic signed [37:0] n_w, nh_w, xy_w, nb_w, t_w, px, py, pz;
   side_type           side_m [0:1];

   assign n_w  = $signed({2'b0, dv[DIV_STEPS].bits});
   assign nh_w = n_w + 38'(side_dv[DIV_STEPS].h);

   always_ff @(posedge clock) begin
      if (advance) begin
         side_m[0] <= side_dv[DIV_STEPS];
         side_m[1] <= side_m[0];
      end
   end

   g2e_mulq30 u_mul_xy (
      .clock(clock), .en(advance), .v(nh_w), .c(side_dv[DIV_STEPS].clat), .p(xy_w));
   g2e_mulq30 u_mul_nb (
      .clock(clock), .en(advance), .v(n_w), .c($signed({1'b0, omf2_ff})), .p(nb_w));

   assign t_w = nb_w + 38'(side_m[1].h);

   g2e_mulq30 u_mul_x (
      .clock(clock), .en(advance), .v(xy_w), .c(side_m[1].clon), .p(px));
   g2e_mulq30 u_mul_y (
      .clock(clock), .en(advance), .v(xy_w), .c(side_m[1].slon), .p(py));
   g2e_mulq30 u_mul_z (
      .clock(clock), .en(advance), .v(t_w), .c(side_m[1].slat), .p(pz));

   // ---- output word register
   logic signed [33:0] x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= sat(px);
         y_ff <= sat(py);
         z_ff <= sat(pz);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_mm  = x_ff;
   assign rsp_y_mm  = y_ff;
   assign rsp_z_mm  = z_ff;

   // ---- assertions
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_x_mm <= OUT_LIMIT && rsp_x_mm >= -OUT_LIMIT &&
                     rsp_y_mm <= OUT_LIMIT && rsp_y_mm >= -OUT_LIMIT &&
                     rsp_z_mm <= OUT_LIMIT && rsp_z_mm >= -OUT_LIMIT))
      else $error("result word outside saturation range");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff))
      else $error("pipeline moved while result word stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && valid_ff == '0))
      else $error("valid words present after reset");

endmodule

@@ tb/geodetic_to_ecef_top_tb.sv @@
// geodetic_to_ecef_top_tb: self-checking testbench for the geodetic to ECEF converter.
// Runs a directed table, then random words under three idling mixes; depends on g2e_pkg.
`timescale 1ns / 100ps

module geodetic_to_ecef_top_tb;
   import g2e_pkg::*;

   localparam int    STEPS      = 32;
   localparam int    LATENCY    = STEPS + 77;
   localparam int    QUIET_MAX  = 4000;
   localparam int    RAND_WORDS = 1700;
   localparam longint SAT_MM    = 64'sd6500000000;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } ecef_t;

   typedef struct {
      bit                 is_csr;
      logic [7:0]         idx;
      logic [36:0]        data;
      logic signed [31:0] lat;
      logic signed [31:0] lon;
      logic signed [27:0] h;
      bit                 typed;
      ecef_t              want;
   } row_t;

   typedef struct {
      bit    typed;
      ecef_t want;
   } tag_t;

   logic               clock, reset;
   logic               req_valid, req_stall;
   logic signed [31:0] req_latitude, req_longitude;
   logic signed [27:0] req_height_mm;
   logic               rsp_valid, rsp_stall;
   logic signed [33:0] rsp_x_mm, rsp_y_mm, rsp_z_mm;
   logic               csr_valid, csr_ready;
   logic [7:0]         csr_index;
   logic [36:0]        csr_data;

   geodetic_to_ecef_top DUT (.*);

   // model copy of the CSRs
   logic [33:0] axis_mm;
   logic [36:0] flat_q40;

   ecef_t  ecef_q[$];
   tag_t   tag_q[$];
   int     send_idle_pct, recv_stall_pct;
   int     mismatches, quiet_cycles;

   const longint atan_bam[STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic longint scale_q30(input longint v, input longint c);
      logic signed [95:0] pv, pc, p;
      pv = v;
      pc = c;
      p  = pv * pc + 96'sd536870912;
      return longint'(p >>> 30);
   endfunction

   function automatic void rotate(input longint ang, output longint sn, output longint cs);
      longint z, x, y, dx, dy;
      bit     flip;
      z = ang; x = 652032874; y = 0; flip = 0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648; flip = 1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648; flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_bam[i];
         end else begin
            x += dx; y -= dy; z += atan_bam[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      sn = y;
      cs = x;
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] d);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (d >= res + bitv) begin
            d -= res + bitv; res = (res >> 1) + bitv;
         end else
            res >>= 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [33:0] clip(input longint v);
      if (v > SAT_MM) v = SAT_MM;
      if (v < -SAT_MM) v = -SAT_MM;
      return v[33:0];
   endfunction

   function automatic ecef_t to_ecef(input logic signed [31:0] lat,
                                     input logic signed [31:0] lon,
                                     input logic signed [27:0] hgt);
      longint      omf, omf2, ee, s2, den, n, xy, slat, clat, slon, clon, h;
      logic [63:0] r, num;
      ecef_t       o;
      h    = hgt;
      omf  = longint'(((64'd1 << 40) - 64'(flat_q40) + 64'd512) >> 10);
      omf2 = (omf * omf + (64'sd1 <<< 29)) >>> 30;
      ee   = 64'sd1073741824 - omf2;
      rotate(longint'(lat), slat, clat);
      rotate(longint'(lon), slon, clon);
      s2 = (slat * slat) >>> 30;
      if (s2 > 64'sd1073741824) s2 = 64'sd1073741824;
      den = 64'sd1073741824 - ((ee * s2) >>> 30);
      if (den < 1) den = 1;
      r = root64(64'(den) << 30);
      if (r == 0) r = 1;
      num = 64'(axis_mm) << 30;
      n   = longint'(num / r);
      xy  = scale_q30(n + h, clat);
      o.x = clip(scale_q30(xy, clon));
      o.y = clip(scale_q30(xy, slon));
      o.z = clip(scale_q30(scale_q30(n, omf2) + h, slat));
      return o;
   endfunction

   // monitors: CSR mirror, prediction on accept, checking, watchdog
   always @(posedge clock) begin
      ecef_t w, got;
      tag_t  t;
      if (reset) begin
         axis_mm  <= AXIS_RESET;
         flat_q40 <= FLAT_RESET;
         quiet_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_AXIS) axis_mm <= csr_data[33:0];
            else if (csr_index == CSR_FLAT) flat_q40 <= csr_data;
         end
         if (req_valid && !req_stall) begin
            t = tag_q.pop_front();
            ecef_q.push_back(t.typed ? t.want
                             : to_ecef(req_latitude, req_longitude, req_height_mm));
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_x_mm, rsp_y_mm, rsp_z_mm};
            if (ecef_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word x=%0d y=%0d z=%0d",
                                              got.x, got.y, got.z);
            end else begin
               w = ecef_q.pop_front();
               if (got !== w) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: want x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                              w.x, w.y, w.z, got.x, got.y, got.z);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= QUIET_MAX) begin
            $display("[geodetic_to_ecef_top] ERROR");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   task automatic send_word(input logic signed [31:0] lat, input logic signed [31:0] lon,
                            input logic signed [27:0] h, input bit typed, input ecef_t want);
      tag_t t;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      t.typed = typed;
      t.want  = want;
      tag_q.push_back(t);
      req_valid     <= 1'b1;
      req_latitude  <= lat;
      req_longitude <= lon;
      req_height_mm <= h;
      do @(posedge clock); while (req_stall);
   endtask

   // drain, let the pipe empty, then write one CSR
   task automatic write_csr(input logic [7:0] idx, input logic [36:0] data);
      req_valid <= 1'b0;
      while (ecef_q.size() != 0 || tag_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random();
      logic signed [31:0] lat, lon;
      logic signed [27:0] h;
      lat = $urandom();
      if ($urandom_range(3) != 0) lat = $signed(32'($urandom_range(32'h8000_0000))) - 32'sd1073741824;
      lon = $urandom();
      h   = $urandom();
      if ($urandom_range(3) != 0) h = $signed(28'($urandom_range(200000000))) - 28'sd100000000;
      send_word(lat, lon, h, 1'b0, '0);
   endtask

   initial begin
      row_t  dir_rows[$];
      row_t  rw;
      logic [33:0] ax;
      int    sent;
      reset = 1'b1;
      req_valid = 0; req_latitude = 0; req_longitude = 0; req_height_mm = 0;
      csr_valid = 0; csr_index = 0; csr_data = 0; rsp_stall = 0;
      send_idle_pct = 0; recv_stall_pct = 0; mismatches = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows = '{
         '{0, 0, 0, 0, 0, 0, 0, '0},
         '{0, 0, 0, 32'sh4000_0000, 0, 28'sd100000000, 0, '0},
         '{0, 0, 0, -32'sh4000_0000, 32'sh4000_0000, -28'sd100000000, 0, '0},
         '{0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 28'sh7FF_FFFF, 0, '0},
         '{0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 28'sh800_0000, 0, '0},
         '{0, 0, 0, 32'sh2000_0000, -32'sh4000_0000, 12345, 0, '0},
         '{0, 0, 0, 32'sh5555_5555, 32'shAAAA_AAAA, 28'h555_5555, 0, '0},
         '{0, 0, 0, 32'shAAAA_AAAA, 32'sh5555_5555, 28'hAAA_AAAA, 0, '0},
         '{1, CSR_AXIS, 0, 0, 0, 0, 0, '0},
         '{0, 0, 0, 32'sh1234_5678, 32'sh4000_0000, 0, 1, '0},
         '{0, 0, 0, -32'sh4000_0000, 32'sh7FFF_FFFF, 0, 1, '0},
         '{1, CSR_AXIS, 37'h3_FFFF_FFFF, 0, 0, 0, 0, '0},
         '{0, 0, 0, 0, 0, 28'sd100000000, 0, '0},
         '{0, 0, 0, 32'sh4000_0000, 32'sh4000_0000, 28'sd100000000, 0, '0},
         '{1, CSR_FLAT, 0, 0, 0, 0, 0, '0},
         '{0, 0, 0, 32'sh2000_0000, 32'sh2000_0000, 0, 0, '0},
         '{1, CSR_FLAT, 37'h1F_FFFF_FFFF, 0, 0, 0, 0, '0},
         '{1, CSR_AXIS, 37'd1000000000, 0, 0, 0, 0, '0},
         '{0, 0, 0, 32'sh3000_0000, -32'sh6000_0000, -28'sd5000, 0, '0},
         '{1, 8'd2, 37'h0_0000_1234, 0, 0, 0, 0, '0},
         '{1, 8'hFF, 37'h1F_FFFF_FFFF, 0, 0, 0, 0, '0},
         '{0, 0, 0, -32'sh3000_0000, 32'sh6000_0000, 28'sd5000, 0, '0},
         '{1, CSR_AXIS, AXIS_RESET, 0, 0, 0, 0, '0},
         '{1, CSR_FLAT, FLAT_RESET, 0, 0, 0, 0, '0}};
      foreach (dir_rows[i]) begin
         rw = dir_rows[i];
         if (rw.is_csr) write_csr(rw.idx, rw.data);
         else send_word(rw.lat, rw.lon, rw.h, rw.typed, rw.want);
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct  = (ph == 0) ? 21 : (ph == 1) ? 73 : 0;
         recv_stall_pct = (ph == 0) ? 73 : (ph == 1) ? 21 : 0;
         sent = 0;
         for (int k = 0; sent < RAND_WORDS / 3; k++) begin
            // new ellipsoid every so often; extremes included
            if (k % 140 == 139) begin
               case ($urandom_range(3))
                  0: ax = 34'd1000000000;
                  1: ax = 34'd10000000000;
                  default: ax = 34'd1000000000 + 34'($urandom_range(32'hFFFF_FFFF)) * 2;
               endcase
               write_csr(CSR_AXIS, 37'(ax));
               write_csr(CSR_FLAT, $urandom_range(1) ? 37'($urandom_range(32'hFFFF_FFFF))
                                                     : 37'(64'd109951162777));
            end
            if ($urandom_range(9) == 0) begin
               // idle-free burst
               send_idle_pct = 0;
               repeat (10) send_random();
               sent += 10;
               send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 73 : 0;
            end else begin
               send_random();
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (ecef_q.size() != 0 || tag_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && ecef_q.size() == 0)
         $display("[geodetic_to_ecef_top] OK");
      else
         $display("[geodetic_to_ecef_top] ERROR");
      $finish;
   end

endmodule

@@ geodetic_to_ecef_top.f @@
src/g2e_pkg.sv
src/g2e_cordic_cell.sv
src/g2e_sqrt_cell.sv
src/g2e_div_cell.sv
src/g2e_mulq30.sv
src/geodetic_to_ecef_top.sv
tb/geodetic_to_ecef_top_tb.sv
